FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the LED blink controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define LBC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define LBC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/lbc_pkg.sv
// Shared constants and types of the LED blink controller.
package lbc_pkg;

	localparam int LedCount = 2;
	localparam logic [7:0] PeriodReset = 8'd3;

	typedef enum logic [1:0] {
		CmdTick    = 2'd0,
		CmdSwitch  = 2'd1,
		CmdOneshot = 2'd2,
		CmdCont    = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic      advance;
		logic      sel;
		cmd_kind_t kind;
		logic      switch_on;
		logic [7:0] on_ticks;
		logic [7:0] off_ticks;
	} lbc_cmd_t;

endpackage

FILE: hw/rtl/lbc_led_cell.sv
// State and update logic of one LED: mode, blink counter, limits and level.
module lbc_led_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  lbc_pkg::lbc_cmd_t cmd,
	output logic             level_next
);
	import lbc_pkg::*;

	typedef enum logic [1:0] {
		ModeOff     = 2'd0,
		ModeOn      = 2'd1,
		ModeOneshot = 2'd2,
		ModeCont    = 2'd3
	} led_mode_t;

	led_mode_t  mode_q;
	logic [7:0] count_q;
	logic [7:0] on_limit_q;
	logic [7:0] cycle_limit_q;
	logic       level_q;
	logic [7:0] count_inc;

	assign count_inc = count_q + 8'd1;

	// The level after this beat, so that the result carries the updated value.
	always_comb begin
		level_next = level_q;
		if (cmd.sel) begin
			case (cmd.kind)
				CmdSwitch:  level_next = cmd.switch_on;
				CmdOneshot: level_next = 1'b1;
				CmdCont:    level_next = 1'b1;
				default:    level_next = level_q;
			endcase
		end else if (cmd.advance) begin
			case (mode_q)
				ModeOneshot: begin
					if (count_inc >= on_limit_q) level_next = 1'b0;
				end
				ModeCont: begin
					if (count_inc >= cycle_limit_q) level_next = 1'b1;
					else if (count_inc == on_limit_q) level_next = 1'b0;
				end
				default: level_next = level_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= ModeOff;
			count_q       <= 8'd0;
			on_limit_q    <= 8'd0;
			cycle_limit_q <= 8'd0;
			level_q       <= 1'b1;
		end else begin
			level_q <= level_next;
			if (cmd.sel) begin
				case (cmd.kind)
					CmdSwitch: begin
						mode_q <= cmd.switch_on ? ModeOn : ModeOff;
					end
					CmdOneshot: begin
						on_limit_q <= cmd.on_ticks;
						count_q    <= 8'd0;
						mode_q     <= ModeOneshot;
					end
					CmdCont: begin
						on_limit_q    <= cmd.on_ticks;
						cycle_limit_q <= cmd.on_ticks + cmd.off_ticks;
						count_q       <= 8'd0;
						mode_q        <= ModeCont;
					end
					default: mode_q <= mode_q;
				endcase
			end else if (cmd.advance) begin
				case (mode_q)
					ModeOneshot: begin
						count_q <= count_inc;
						if (count_inc >= on_limit_q) mode_q <= ModeOff;
					end
					ModeCont: begin
						count_q <= (count_inc >= cycle_limit_q) ? 8'd0 : count_inc;
					end
					default: count_q <= count_q;
				endcase
			end
		end
	end

endmodule

FILE: hw/rtl/led_blink_controller_top.sv
// Top level of the LED blink controller: input stage, prescaler, LED cells, result queue.
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid / in_stall       | mode, led_index, switch_on, on_ticks, off_ticks
//  out     | output    | out_valid / out_stall     | led_levels
//  cfg     | input     | cfg_wr_en                 | cfg_wr_data (prescale period)
//
// One item per cycle unless in_stall is raised; results pass the input stage and result queue.
// The rate is set by the single input stage, which feeds all LED cells at once.
// Asynchronous reset sets the period and prescaler to 3, all LEDs off-mode, levels high.
// A two-entry result queue absorbs output stalls; in_stall is raised only when the
// queue is full, the output is stalled and the input stage holds an item.
`include "assert_macros.svh"

module led_blink_controller_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic       led_index,
	input  logic       switch_on,
	input  logic [7:0] on_ticks,
	input  logic [7:0] off_ticks,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] led_levels,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);
	import lbc_pkg::*;

	logic       valid_s1;
	cmd_kind_t  kind_s1;
	logic       led_index_s1;
	logic       switch_on_s1;
	logic [7:0] on_ticks_s1;
	logic [7:0] off_ticks_s1;

	logic [7:0] period_q;
	logic [7:0] prescale_q;

	logic [1:0] queue_cnt_q;
	logic [1:0] queue0_q;
	logic [1:0] queue1_q;

	logic       accept;
	logic       fire_s1;
	logic       pop;
	logic       advance;
	logic       is_tick;
	logic [LedCount-1:0] level_next;
	logic [1:0] levels_next;

	assign pop      = out_valid && !out_stall;
	assign fire_s1  = valid_s1 && ((queue_cnt_q != 2'd2) || pop);
	assign in_stall = valid_s1 && !fire_s1;
	assign accept   = in_valid && !in_stall;
	assign is_tick  = (kind_s1 == CmdTick);
	// The prescaler reloads the period on this beat exactly when it holds one.
	assign advance  = fire_s1 && is_tick && (prescale_q == 8'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1      <= cmd_kind_t'(mode);
			led_index_s1 <= led_index;
			switch_on_s1 <= switch_on;
			on_ticks_s1  <= on_ticks;
			off_ticks_s1 <= off_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PeriodReset;
			prescale_q <= PeriodReset;
		end else begin
			if (cfg_wr_en) period_q <= cfg_wr_data;
			if (fire_s1 && is_tick) begin
				prescale_q <= advance ? period_q : prescale_q - 8'd1;
			end
		end
	end

	for (genvar i = 0; i < LedCount; i++) begin : g_led
		lbc_cmd_t cmd;
		always_comb begin
			cmd.advance   = advance;
			cmd.sel       = fire_s1 && !is_tick && (int'(led_index_s1) == i);
			cmd.kind      = kind_s1;
			cmd.switch_on = switch_on_s1;
			cmd.on_ticks  = on_ticks_s1;
			cmd.off_ticks = off_ticks_s1;
		end
		lbc_led_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.level_next (level_next[i])
		);
	end

	// Result bits for LEDs that do not exist read zero.
	for (genvar b = 0; b < 2; b++) begin : g_levels
		if (b < LedCount) begin : g_on
			assign levels_next[b] = level_next[b];
		end else begin : g_off
			assign levels_next[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_cnt_q <= 2'd0;
		end else begin
			case ({fire_s1, pop})
				2'b10:   queue_cnt_q <= queue_cnt_q + 2'd1;
				2'b01:   queue_cnt_q <= queue_cnt_q - 2'd1;
				default: queue_cnt_q <= queue_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({fire_s1, pop})
			2'b10: begin
				if (queue_cnt_q == 2'd0) queue0_q <= levels_next;
				else queue1_q <= levels_next;
			end
			2'b01: begin
				queue0_q <= queue1_q;
			end
			2'b11: begin
				if (queue_cnt_q == 2'd1) begin
					queue0_q <= levels_next;
				end else begin
					queue0_q <= queue1_q;
					queue1_q <= levels_next;
				end
			end
			default: queue0_q <= queue0_q;
		endcase
	end

	assign out_valid  = (queue_cnt_q != 2'd0);
	assign led_levels = queue0_q;

	`LBC_ASSERT(a_queue_bound, queue_cnt_q != 2'd3, "result queue count out of range")
	`LBC_ASSERT_IMP(a_stall_cause, in_stall, (queue_cnt_q == 2'd2) && out_stall, "input stalled without a full stalled queue")
	`LBC_ASSERT(a_empty_push, (fire_s1 && (queue_cnt_q == 2'd0)) |=> (out_valid && (led_levels == $past(levels_next))), "result beat lost on empty queue")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for led_blink_controller_top with a per-item blink predictor.
`timescale 1ns / 1ps

module tb_top;
	import lbc_pkg::*;

	typedef enum logic [1:0] {
		LedOff,
		LedOn,
		LedOneshot,
		LedCont
	} led_state_t;

	localparam int LongHold = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] mode = CmdTick;
	logic       led_index = 1'b0;
	logic       switch_on = 1'b0;
	logic [7:0] on_ticks = 8'd0;
	logic [7:0] off_ticks = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] led_levels;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;

	// Predictor state.
	logic [7:0] period_reg;
	logic [7:0] presc_cnt;
	led_state_t led_state [LedCount];
	logic [7:0] blink_cnt [LedCount];
	logic [7:0] on_lim [LedCount];
	logic [7:0] cyc_lim [LedCount];
	logic       level [LedCount];

	logic [1:0] levels_due [$];
	logic [1:0] levels_exp;

	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	int hold_reqs = 0;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int period_writes = 0;
	int in_stall_cycles = 0;

	led_blink_controller_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.led_index   (led_index),
		.switch_on   (switch_on),
		.on_ticks    (on_ticks),
		.off_ticks   (off_ticks),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_levels  (led_levels),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #6 clk = ~clk;

	function automatic logic [1:0] predict_levels(cmd_kind_t kind, logic idx, logic sw,
			logic [7:0] on_t, logic [7:0] off_t);
		if (kind == CmdTick) begin
			presc_cnt = presc_cnt - 8'd1;
			if (presc_cnt == 8'd0) begin
				presc_cnt = period_reg;
				for (int i = 0; i < LedCount; i++) begin
					if (led_state[i] == LedOneshot) begin
						blink_cnt[i] = blink_cnt[i] + 8'd1;
						if (blink_cnt[i] >= on_lim[i]) begin
							level[i] = 1'b0;
							led_state[i] = LedOff;
						end
					end else if (led_state[i] == LedCont) begin
						blink_cnt[i] = blink_cnt[i] + 8'd1;
						if (blink_cnt[i] >= cyc_lim[i]) begin
							level[i] = 1'b1;
							blink_cnt[i] = 8'd0;
						end else if (blink_cnt[i] == on_lim[i]) begin
							level[i] = 1'b0;
						end
					end
				end
			end
		end else if (kind == CmdSwitch) begin
			led_state[idx] = sw ? LedOn : LedOff;
			level[idx] = sw;
		end else begin
			// Any blink command restarts its counter with the LED lit.
			on_lim[idx] = on_t;
			blink_cnt[idx] = 8'd0;
			level[idx] = 1'b1;
			if (kind == CmdOneshot) begin
				led_state[idx] = LedOneshot;
			end else begin
				cyc_lim[idx] = on_t + off_t;
				led_state[idx] = LedCont;
			end
		end
		return {level[1], level[0]};
	endfunction

	// Result checker; also counts cycles in which the block refused input.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall)
			in_stall_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (levels_due.size() == 0) begin
				$error("unexpected result beat: led_levels=%b", led_levels);
				errors++;
			end else begin
				levels_exp = levels_due.pop_front();
				results_seen++;
				if (led_levels !== levels_exp) begin
					$error("led_levels: expected %b, actual %b", levels_exp, led_levels);
					errors++;
				end
			end
		end
	end

	// Receiver: random stall after each beat when enabled, plus long hold-offs on request.
	initial begin
		int stall_left;
		int holds_served;
		bit took;
		stall_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			took = arst_n && out_valid && !out_stall;
			@(negedge clk);
			if (hold_reqs != holds_served) begin
				holds_served++;
				out_stall = 1'b1;
				repeat (LongHold) @(negedge clk);
				out_stall = 1'b0;
				stall_left = 0;
			end else begin
				if (took)
					stall_left = !rx_idle_en ? 0 :
						($urandom_range(0, 1) ? 0 : $urandom_range(1, 16));
				if (stall_left > 0) begin
					out_stall = 1'b1;
					stall_left--;
				end else begin
					out_stall = 1'b0;
				end
			end
		end
	end

	// Called and returns at a falling edge.
	task automatic send_cmd(cmd_kind_t kind, logic idx, logic sw, logic [7:0] on_t,
			logic [7:0] off_t);
		int gap;
		gap = !tx_idle_en ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 16));
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		mode = kind;
		led_index = idx;
		switch_on = sw;
		on_ticks = on_t;
		off_ticks = off_t;
		do @(posedge clk); while (in_stall);
		levels_due.push_back(predict_levels(kind, idx, sw, on_t, off_t));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (levels_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_period(logic [7:0] value);
		wait_drained();
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		period_reg = value;
		period_writes++;
	endtask

	// Mostly ticks and short blink times so that blink cycles complete often.
	task automatic send_random_cmd();
		int r;
		cmd_kind_t kind;
		logic [7:0] on_t;
		logic [7:0] off_t;
		r = $urandom_range(0, 99);
		kind = (r < 55) ? CmdTick : (r < 65) ? CmdSwitch : (r < 82) ? CmdOneshot : CmdCont;
		on_t = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 6)) : 8'($urandom);
		off_t = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 6)) : 8'($urandom);
		send_cmd(kind, 1'($urandom), 1'($urandom), on_t, off_t);
	endtask

	task automatic test_directed();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_cmd(CmdSwitch, 1'b0, 1'b0, 8'd0, 8'd0);
		send_cmd(CmdSwitch, 1'b1, 1'b0, 8'd0, 8'd0);
		send_cmd(CmdSwitch, 1'b0, 1'b1, 8'd0, 8'd0);
		send_cmd(CmdSwitch, 1'b1, 1'b1, 8'd0, 8'd0);
		// A zero-length one-shot ends at the first prescaled update.
		send_cmd(CmdOneshot, 1'b0, 1'b0, 8'd0, 8'd0);
		send_cmd(CmdOneshot, 1'b1, 1'b1, 8'd255, 8'd255);
		repeat (3) send_cmd(CmdTick, 1'b0, 1'b0, 8'd0, 8'd0);
		// On plus off wraps to 44, below the on time.
		send_cmd(CmdCont, 1'b0, 1'b0, 8'd200, 8'd100);
		send_cmd(CmdCont, 1'b1, 1'b0, 8'd0, 8'd0);
		repeat (3) send_cmd(CmdTick, 1'b1, 1'b1, 8'd255, 8'd255);
		send_cmd(CmdCont, 1'b0, 1'b1, 8'd1, 8'd2);
		// Restart of a running blink.
		send_cmd(CmdOneshot, 1'b1, 1'b0, 8'd1, 8'd0);
		repeat (6) send_cmd(CmdTick, 1'b0, 1'b0, 8'd0, 8'd0);
		send_cmd(CmdSwitch, 1'b1, 1'b0, 8'd255, 8'd255);
	endtask

	task automatic test_random(int count, logic [7:0] period, bit tx_idle, bit rx_idle);
		write_period(period);
		tx_idle_en = tx_idle;
		rx_idle_en = rx_idle;
		repeat (count) send_random_cmd();
	endtask

	task automatic test_period_extremes();
		// A zero period reloads zero, so the next tick wraps the prescaler to 255.
		write_period(8'd0);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_cmd(CmdCont, 1'b0, 1'b0, 8'd1, 8'd1);
		repeat (40) send_random_cmd();
		test_random(60, 8'd255, 1'b1, 1'b0);
		test_random(60, 8'd1, 1'b0, 1'b1);
	endtask

	task automatic test_backpressure();
		wait_drained();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_reqs++;
		repeat (30) send_random_cmd();
		wait_drained();
	endtask

	initial begin
		period_reg = PeriodReset;
		presc_cnt = PeriodReset;
		for (int i = 0; i < LedCount; i++) begin
			led_state[i] = LedOff;
			blink_cnt[i] = 8'd0;
			on_lim[i] = 8'd0;
			cyc_lim[i] = 8'd0;
			level[i] = 1'b1;
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_period_extremes();
		test_random(400, 8'd1, 1'b1, 1'b1);
		test_backpressure();
		test_random(300, 8'd2, 1'b0, 1'b0);
		test_random(400, 8'($urandom_range(1, 7)), 1'b1, 1'b1);
		test_backpressure();

		wait_drained();
		repeat (8) @(negedge clk);
		if (levels_due.size() != 0) begin
			$error("%0d expected results never arrived", levels_due.size());
			errors++;
		end
		$display("Sent %0d items, checked %0d results, %0d period writes (0, 1 and 255 among them).",
			items_sent, results_seen, period_writes);
		$display("Input was held off for %0d cycles under output back-pressure.",
			in_stall_cycles);
		if (errors == 0) begin
			$display("** led_blink_controller_top: PASSED **");
		end else begin
			$display("** led_blink_controller_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#4800000;
		$display("Timeout with %0d results outstanding.", levels_due.size());
		$display("** led_blink_controller_top: FAILED **");
		$finish;
	end

endmodule

FILE: led_blink_controller_top.f
+incdir+hw/rtl
hw/rtl/lbc_pkg.sv
hw/rtl/lbc_led_cell.sv
hw/rtl/led_blink_controller_top.sv
tb/tb_top.sv
